FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RTL, included by the multiplier.
// The macros assume the module has a clock named clock and an active-high
// reset named reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

FILE: design/gf2mv_pkg.sv
// ---------------------------------------------------------------------------
// GF(2) matrix-vector multiplier package
// Request operation codes and the sequencer state type.
// ---------------------------------------------------------------------------
package gf2mv_pkg;

   // Request operation codes.
   localparam logic OP_KEY_WRITE = 1'b0;
   localparam logic OP_DATA      = 1'b1;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

FILE: design/gf2mv_ram.sv
// ---------------------------------------------------------------------------
// GF(2) matrix-vector multiplier RAM
// Simple dual-port synchronous RAM, one write port and one registered read.
// ---------------------------------------------------------------------------
module gf2mv_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/gf2_matrix_vector_multiply.sv
// ---------------------------------------------------------------------------
// GF(2) matrix-vector multiplier
// Multiplies an input vector by a key matrix held in on-chip RAM.
// ---------------------------------------------------------------------------
// The key matrix lives in VECTOR_WORDS RAMs, one per row word, each holding
// one WORD_BITS-wide word per key column; all row words of a column are read
// together. A key write beat leaves the block idle, ready for the next beat.
// A data beat scans its WORD_BITS bits, one key column read per cycle; the
// block takes no request until the last column returns from the read port of
// the key RAMs. After the last data word of a vector the block delivers
// VECTOR_WORDS product beats, one per cycle while the result side does not
// stall, and clears its accumulators. Key entries must be written before a
// data word reads them. The key RAMs need no clearing pass after reset.
// ---------------------------------------------------------------------------
module gf2_matrix_vector_multiply
   import gf2mv_pkg::*;
#(
   parameter int VECTOR_WORDS = 4,
   parameter int WORD_BITS    = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [9:0]  req_key_index,
   input  logic [63:0] req_key_word,
   input  logic [63:0] req_data_word,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_product_word,
   output logic [1:0]  rsp_product_index,
   output logic        rsp_last
);

`include "assert_macros.svh"

   localparam int KEY_COLUMNS = VECTOR_WORDS * WORD_BITS;
   localparam int KEY_DEPTH   = VECTOR_WORDS * KEY_COLUMNS;
   localparam int COL_W       = $clog2(KEY_COLUMNS);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int CNT_W       = (VECTOR_WORDS > 1) ? $clog2(VECTOR_WORDS) : 1;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       word_cnt_ff, word_cnt_in;
   logic [CNT_W-1:0]       out_cnt_ff, out_cnt_in;
   logic [BIT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic                   issue_ff, issue_in;
   logic                   pend_ff, pend_in;
   logic                   pend_bit_ff, pend_bit_in;
   logic [WORD_BITS-1:0]   x_ff, x_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [WORD_BITS-1:0]   acc_ff [VECTOR_WORDS];
   logic [WORD_BITS-1:0]   acc_in [VECTOR_WORDS];
   logic [WORD_BITS-1:0]   key_rd_data [VECTOR_WORDS];

   logic                   req_accept;
   logic                   rsp_accept;
   logic                   key_wr_hit;
   logic [CNT_W-1:0]       wr_row;
   logic [COL_W-1:0]       wr_col;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign rsp_accept = rsp_valid && !rsp_stall;

   // Key write decode: split the flat index into row word and column.
   always_comb begin
      wr_row = '0;
      for (int m = 1; m < VECTOR_WORDS; m++) begin
         if (int'(req_key_index) >= m * KEY_COLUMNS) begin
            wr_row = CNT_W'(m);
         end
      end
      wr_col = COL_W'(int'(req_key_index) - int'(wr_row) * KEY_COLUMNS);
   end

   assign key_wr_hit = req_accept && (req_op == OP_KEY_WRITE)
                       && (int'(req_key_index) < KEY_DEPTH);

   // One key RAM per row word, all read at the same column.
   for (genvar k = 0; k < VECTOR_WORDS; k++) begin : g_key
      gf2mv_ram #(
         .WIDTH (WORD_BITS),
         .DEPTH (KEY_COLUMNS)
      ) u_key_ram (
         .clock   (clock),
         .wr_en   (key_wr_hit && (wr_row == CNT_W'(k))),
         .wr_addr (wr_col),
         .wr_data (req_key_word[WORD_BITS-1:0]),
         .rd_en   (issue_ff),
         .rd_addr (col_ff),
         .rd_data (key_rd_data[k])
      );
   end

   // Sequencer: issue one column read per bit, fold returning columns in.
   always_comb begin
      state_in    = state_ff;
      word_cnt_in = word_cnt_ff;
      out_cnt_in  = out_cnt_ff;
      bit_cnt_in  = bit_cnt_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pend_bit_in = pend_bit_ff;
      x_in        = x_ff;
      col_in      = col_ff;
      acc_in      = acc_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_op == OP_DATA)) begin
               x_in       = req_data_word[WORD_BITS-1:0];
               col_in     = COL_W'(int'(word_cnt_ff) * WORD_BITS);
               bit_cnt_in = '0;
               issue_in   = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Read issue for the current bit.
            if (issue_ff) begin
               pend_in     = 1'b1;
               pend_bit_in = x_ff[0];
               x_in        = x_ff >> 1;
               col_in      = col_ff + COL_W'(1);
               bit_cnt_in  = bit_cnt_ff + BIT_W'(1);
               if (bit_cnt_ff == BIT_W'(WORD_BITS - 1)) begin
                  issue_in = 1'b0;
               end
            end
            // Accumulate the column whose read was issued in the previous cycle, if its bit was set.
            if (pend_ff && pend_bit_ff) begin
               for (int k = 0; k < VECTOR_WORDS; k++) begin
                  acc_in[k] = acc_ff[k] ^ key_rd_data[k];
               end
            end
            // The last column has come back: the word is done.
            if (pend_ff && !issue_ff) begin
               if (word_cnt_ff == CNT_W'(VECTOR_WORDS - 1)) begin
                  word_cnt_in = '0;
                  out_cnt_in  = '0;
                  state_in    = ST_EMIT;
               end else begin
                  word_cnt_in = word_cnt_ff + CNT_W'(1);
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_accept) begin
               if (out_cnt_ff == CNT_W'(VECTOR_WORDS - 1)) begin
                  for (int k = 0; k < VECTOR_WORDS; k++) begin
                     acc_in[k] = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  out_cnt_in = out_cnt_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         word_cnt_ff <= '0;
         out_cnt_ff  <= '0;
         issue_ff    <= 1'b0;
         pend_ff     <= 1'b0;
         for (int k = 0; k < VECTOR_WORDS; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         word_cnt_ff <= word_cnt_in;
         out_cnt_ff  <= out_cnt_in;
         issue_ff    <= issue_in;
         pend_ff     <= pend_in;
         acc_ff      <= acc_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      bit_cnt_ff  <= bit_cnt_in;
      pend_bit_ff <= pend_bit_in;
      x_ff        <= x_in;
      col_ff      <= col_in;
   end

   // Response payload straight from the accumulators.
   assign rsp_product_word  = 64'(acc_ff[out_cnt_ff]);
   assign rsp_product_index = 2'(out_cnt_ff);
   assign rsp_last          = (out_cnt_ff == CNT_W'(VECTOR_WORDS - 1));

   // A response beat is only shown once the word counter has wrapped.
   `ASSERT_CLK(a_emit_counter, rsp_valid |-> (word_cnt_ff == '0),
               "response shown while a vector is still incomplete")
   // The block never takes a request while a column read is in flight.
   `ASSERT_NEVER(a_idle_quiet, !req_stall && (issue_ff || pend_ff),
                 "request side open during a column scan")
   // The accumulators are cleared after the last product beat.
   `ASSERT_CLK(a_acc_clear, (rsp_accept && rsp_last) |=> (acc_ff[0] == '0),
               "accumulators not cleared after the last product beat")

endmodule

FILE: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// GF(2) matrix-vector multiplier testbench
// Loads a spread of key columns, then runs directed and random request beats
// through the block. Data bits only select key columns whose row words have
// all been written. Each accepted beat updates a local GF(2) predictor, and
// each product beat is checked against the oldest predicted product. Both
// channels see random idle and stall bursts, except in calm stretches and near the end of the run.
// ---------------------------------------------------------------------------
module tb_top
   import gf2mv_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VECTOR_WORDS  = 4;
   localparam int WORD_BITS     = 64;
   localparam int KEY_COLUMNS   = VECTOR_WORDS * WORD_BITS;
   localparam int KEY_DEPTH     = VECTOR_WORDS * KEY_COLUMNS;
   localparam int RANDOM_ITEMS  = 160;
   localparam int LOAD_STRIDE   = 9;
   localparam int IDLE_MAX      = 13;
   localparam int QUIET_ITEMS   = 40;
   localparam int SETTLE_CYCLES = 2 * (WORD_BITS + 2);
   localparam int CYCLE_LIMIT   = 500000;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      logic        op;
      logic [9:0]  key_index;
      logic [63:0] key_word;
      logic [63:0] data_word;
   } request_type;

   typedef struct packed {
      logic [63:0] word;
      logic [1:0]  index;
      logic        last;
   } product_type;

   // Clock, reset and block ports.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_KEY_WRITE;
   logic [9:0]  req_key_index = '0;
   logic [63:0] req_key_word = '0;
   logic [63:0] req_data_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_product_word;
   logic [1:0]  rsp_product_index;
   logic        rsp_last;

   // Stimulus, predictor state and bookkeeping.
   request_type request_queue[$];
   product_type pending_products[$];
   logic [63:0] key_matrix[KEY_DEPTH];
   logic [63:0] partial_sums[VECTOR_WORDS];
   bit          key_loaded[KEY_DEPTH];
   int          gen_data_count = 0;
   int          vector_word_count = 0;
   int          accepted_count = 0;
   int          total_items = 0;
   int          failures = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   int          cycle_count = 0;

   gf2_matrix_vector_multiply #(
      .VECTOR_WORDS(VECTOR_WORDS),
      .WORD_BITS(WORD_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_key_index(req_key_index),
      .req_key_word(req_key_word),
      .req_data_word(req_data_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_product_word(rsp_product_word),
      .rsp_product_index(rsp_product_index),
      .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Input vector words of several shapes: empty, full, one bit, or random.
   function automatic logic [63:0] rand_pattern();
      case ($urandom_range(0, 5))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2: begin
            return 64'd1 << $urandom_range(0, WORD_BITS - 1);
         end
         default: begin
            return rand64();
         end
      endcase
   endfunction

   // Bits of a vector word whose key columns are written in every row word.
   function automatic logic [63:0] loaded_columns(input int pos);
      logic [63:0] mask;
      mask = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         mask[j] = 1'b1;
         for (int k = 0; k < VECTOR_WORDS; k++) begin
            if (!key_loaded[k * KEY_COLUMNS + pos * WORD_BITS + j]) begin
               mask[j] = 1'b0;
            end
         end
      end
      return mask;
   endfunction

   // The unused fields of each beat carry random noise.
   function automatic request_type key_beat(input int idx, input logic [63:0] value);
      request_type beat;
      beat.op          = OP_KEY_WRITE;
      beat.key_index   = 10'(idx);
      beat.key_word    = value;
      beat.data_word   = rand64();
      key_loaded[idx]  = 1'b1;
      return beat;
   endfunction

   // Data bits are limited to key columns that are fully written by then.
   function automatic request_type data_beat(input logic [63:0] value);
      request_type beat;
      int          pos;
      pos = gen_data_count % VECTOR_WORDS;
      gen_data_count++;
      beat.op        = OP_DATA;
      beat.key_index = 10'($urandom_range(0, KEY_DEPTH - 1));
      beat.key_word  = rand64();
      beat.data_word = value & loaded_columns(pos);
      return beat;
   endfunction

   // Idling is allowed outside calm stretches and outside the final part.
   function automatic bit idle_allowed();
      return (cycle_count % 1024 >= 256) && (request_queue.size() >= QUIET_ITEMS);
   endfunction

   // Applies one accepted beat to the GF(2) product predictor.
   task automatic predict_products(input request_type beat);
      int          base;
      product_type product;
      if (beat.op == OP_KEY_WRITE) begin
         key_matrix[beat.key_index] = beat.key_word;
      end else begin
         base = vector_word_count * WORD_BITS;
         for (int j = 0; j < WORD_BITS; j++) begin
            if (beat.data_word[j]) begin
               for (int k = 0; k < VECTOR_WORDS; k++) begin
                  partial_sums[k] ^= key_matrix[k * KEY_COLUMNS + base + j];
               end
            end
         end
         vector_word_count++;
         if (vector_word_count == VECTOR_WORDS) begin
            for (int k = 0; k < VECTOR_WORDS; k++) begin
               product.word  = partial_sums[k];
               product.index = 2'(k);
               product.last  = (k == VECTOR_WORDS - 1);
               pending_products.push_back(product);
               partial_sums[k] = '0;
            end
            vector_word_count = 0;
         end
      end
   endtask

   task automatic note_failure(input string what, input product_type want,
                               input product_type seen);
      failures++;
      if (failures <= REPORT_MAX) begin
         $display("%0s: expected word %h index %0d last %0b, got word %h index %0d last %0b",
                  what, want.word, want.index, want.last,
                  seen.word, seen.index, seen.last);
      end
   endtask

   // Request driver: presents queued beats and holds them while stalled.
   always @(posedge clock) begin : request_driver
      request_type beat;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_products('{req_op, req_key_index, req_key_word, req_data_word});
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
               beat = request_queue.pop_front();
               req_op        <= beat.op;
               req_key_index <= beat.key_index;
               req_key_word  <= beat.key_word;
               req_data_word <= beat.data_word;
               req_valid     <= 1'b1;
               if (idle_allowed() && $urandom_range(0, 5) == 0) begin
                  gap_left = $urandom_range(1, IDLE_MAX);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Product monitor: checks each product beat and drives random stalls.
   always @(posedge clock) begin : product_monitor
      product_type seen;
      product_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_product_word, rsp_product_index, rsp_last};
            if (pending_products.size() == 0) begin
               note_failure("unexpected product beat", '0, seen);
            end else begin
               want = pending_products.pop_front();
               if (seen !== want) begin
                  note_failure("product mismatch", want, seen);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, IDLE_MAX) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("** gf2_matrix_vector_multiply: FAILED **");
      $finish;
   end

   initial begin : run
      int          random_count;
      int          split;
      int          choice;
      int          column;
      logic [63:0] value;

      foreach (partial_sums[k]) begin
         partial_sums[k] = '0;
      end

      // Load a spread of key columns in every vector word position, both
      // edge bits included. Column 0 is all ones and the last column all
      // zeros in every row word.
      for (int idx = 0; idx < KEY_DEPTH; idx++) begin
         if ((idx % WORD_BITS) % LOAD_STRIDE == 0 || idx % WORD_BITS == WORD_BITS - 1) begin
            if (idx % KEY_COLUMNS == 0) begin
               value = '1;
            end else if (idx % KEY_COLUMNS == KEY_COLUMNS - 1) begin
               value = '0;
            end else begin
               value = rand64();
            end
            request_queue.push_back(key_beat(idx, value));
         end
      end

      // Directed vectors: all zero, all ones, and both edge bits alone.
      for (int i = 0; i < VECTOR_WORDS; i++) begin
         request_queue.push_back(data_beat('0));
      end
      for (int i = 0; i < VECTOR_WORDS; i++) begin
         request_queue.push_back(data_beat('1));
      end
      request_queue.push_back(data_beat(64'd1));
      request_queue.push_back(data_beat('0));
      request_queue.push_back(data_beat('0));
      request_queue.push_back(data_beat(64'd1 << (WORD_BITS - 1)));

      // A key write in the middle of a vector feeds the words after it.
      request_queue.push_back(data_beat(rand64()));
      request_queue.push_back(key_beat(KEY_COLUMNS + WORD_BITS + LOAD_STRIDE, '1));
      request_queue.push_back(data_beat(rand64() | (64'd1 << LOAD_STRIDE)));
      request_queue.push_back(data_beat(rand64()));
      request_queue.push_back(data_beat(rand64()));

      // Key writes at the first and last store positions.
      request_queue.push_back(key_beat(0, '0));
      request_queue.push_back(key_beat(KEY_DEPTH - 1, '1));

      // Random part: mostly whole vectors, sometimes with a key write inside,
      // mixed with stand-alone key overwrites and whole new key columns.
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         choice = $urandom_range(0, 9);
         if (choice < 7) begin
            split = ($urandom_range(0, 3) == 0) ? $urandom_range(0, VECTOR_WORDS) : -1;
            for (int i = 0; i < VECTOR_WORDS; i++) begin
               if (i == split) begin
                  request_queue.push_back(key_beat($urandom_range(0, KEY_DEPTH - 1),
                                                   rand64()));
                  random_count++;
               end
               request_queue.push_back(data_beat(rand_pattern()));
               random_count++;
            end
         end else if (choice < 9) begin
            request_queue.push_back(key_beat($urandom_range(0, KEY_DEPTH - 1), rand64()));
            random_count++;
         end else begin
            column = $urandom_range(0, KEY_COLUMNS - 1);
            for (int k = 0; k < VECTOR_WORDS; k++) begin
               request_queue.push_back(key_beat(k * KEY_COLUMNS + column, rand64()));
               random_count++;
            end
         end
      end
      total_items = request_queue.size();

      // Reset.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to be taken and every product to arrive.
      while (accepted_count < total_items) begin
         @(posedge clock);
      end
      while (pending_products.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0 && pending_products.size() == 0) begin
         $display("** gf2_matrix_vector_multiply: PASSED **");
      end else begin
         $display("** gf2_matrix_vector_multiply: FAILED **");
      end
      $finish;
   end

endmodule
